/* hw/rtl/time_of_day_text_parser_unit_macros.svh */
// Assertion macros shared by the time-of-day parser RTL.
`ifndef TIME_OF_DAY_TEXT_PARSER_UNIT_MACROS_SVH
`define TIME_OF_DAY_TEXT_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define TODP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define TODP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/todp_pkg.sv */
// Types and constants shared by the time-of-day parser modules.
`timescale 1ns / 1ps
package todp_pkg;

  localparam int unsigned AccW  = 7;
  localparam int unsigned FracW = 20;

  localparam logic [AccW-1:0] HourMax   = 7'd23;
  localparam logic [AccW-1:0] MinSecMax = 7'd59;
  localparam int unsigned     MsDigitsMax = 3;

  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharColon = 8'h3A;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StBadFormat  = 3'd1,
    StBadHour    = 3'd2,
    StBadMinute  = 3'd3,
    StBadSecond  = 3'd4,
    StEmpty      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PhHour     = 2'd0,
    PhMinute   = 2'd1,
    PhSecond   = 2'd2,
    PhFraction = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       end_of_string;
  } char_item_t;

  typedef struct packed {
    status_e          status;
    logic [4:0]       hour_value;
    logic [5:0]       minute_value;
    logic [5:0]       second_value;
    logic [FracW-1:0] fraction_value;
    logic             resolution_us;
  } result_t;

  // Parser state as it stands after the character in the input register.
  typedef struct packed {
    phase_e           phase;
    logic             cnt_zero;
    logic             frac_long;
    logic [AccW-1:0]  hour;
    logic [AccW-1:0]  minute;
    logic [AccW-1:0]  second;
    logic [FracW-1:0] fraction;
    logic             broken;
    logic             only_blank;
  } scan_t;

endpackage

/* hw/rtl/todp_stream_if.sv */
// Valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
interface todp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/todp_scan.sv */
// Per-character grammar tracking and field accumulators of the parser.
`timescale 1ns / 1ps
module todp_scan #(
  parameter int unsigned FRACTION_DIGITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  todp_pkg::char_item_t item_i,
  output todp_pkg::scan_t     scan_o
);
  import todp_pkg::*;

  localparam int unsigned CntW = $clog2(FRACTION_DIGITS + 1);

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AccW-1:0]  hour_q, hour_d;
  logic [AccW-1:0]  minute_q, minute_d;
  logic [AccW-1:0]  second_q, second_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic             broken_q, broken_d;
  logic             blank_only_q, blank_only_d;

  logic [7:0]      code;
  logic [3:0]      digit;
  logic            is_blank;
  logic            is_digit;
  logic [AccW-1:0] acc_sel;
  logic [AccW-1:0] acc_next;

  assign code     = item_i.char_code;
  assign digit    = code[3:0];
  assign is_blank = (code == CharSpace) || ((code >= CharTab) && (code <= CharCr));
  assign is_digit = (code >= CharZero) && (code <= CharNine);

  always_comb begin
    unique case (phase_q)
      PhHour:   acc_sel = hour_q;
      PhMinute: acc_sel = minute_q;
      default:  acc_sel = second_q;
    endcase
  end

  // Times ten as shift-and-add; a field holds at most one digit here.
  assign acc_next = {acc_sel[AccW-4:0], 3'b000} + {acc_sel[AccW-2:0], 1'b0}
                  + {{(AccW-4){1'b0}}, digit};

  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    second_d     = second_q;
    frac_d       = frac_q;
    broken_d     = broken_q;
    blank_only_d = blank_only_q;
    if (item_i.char_valid) begin
      if (is_blank) begin
        broken_d = 1'b1;
      end else begin
        blank_only_d = 1'b0;
        if (!broken_q) begin
          priority if (is_digit) begin
            if (phase_q == PhFraction) begin
              if (cnt_q >= CntW'(FRACTION_DIGITS)) begin
                broken_d = 1'b1;
              end else begin
                frac_d = {frac_q[FracW-4:0], 3'b000} + {frac_q[FracW-2:0], 1'b0}
                       + {{(FracW-4){1'b0}}, digit};
                cnt_d  = cnt_q + CntW'(1);
              end
            end else if (cnt_q >= CntW'(2)) begin
              broken_d = 1'b1;
            end else begin
              unique case (phase_q)
                PhHour:   hour_d   = acc_next;
                PhMinute: minute_d = acc_next;
                default:  second_d = acc_next;
              endcase
              cnt_d = cnt_q + CntW'(1);
            end
          end else if (code == CharColon) begin
            if ((phase_q == PhFraction) || (cnt_q == '0)) begin
              broken_d = 1'b1;
            end else begin
              unique case (phase_q)
                PhHour:   phase_d = PhMinute;
                PhMinute: phase_d = PhSecond;
                default:  phase_d = PhFraction;
              endcase
              cnt_d = '0;
            end
          end else if (code == CharDot) begin
            if ((phase_q != PhSecond) || (cnt_q == '0)) begin
              broken_d = 1'b1;
            end else begin
              phase_d = PhFraction;
              cnt_d   = '0;
            end
          end else begin
            broken_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    scan_o.phase      = phase_d;
    scan_o.cnt_zero   = (cnt_d == '0);
    scan_o.frac_long  = (cnt_d > CntW'(MsDigitsMax));
    scan_o.hour       = hour_d;
    scan_o.minute     = minute_d;
    scan_o.second     = second_d;
    scan_o.fraction   = frac_d;
    scan_o.broken     = broken_d;
    scan_o.only_blank = blank_only_d;
  end

  // The end-of-string transfer returns every accumulator to its idle value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHour;
      cnt_q        <= '0;
      hour_q       <= '0;
      minute_q     <= '0;
      second_q     <= '0;
      frac_q       <= '0;
      broken_q     <= 1'b0;
      blank_only_q <= 1'b1;
    end else if (step_i) begin
      if (item_i.end_of_string) begin
        phase_q      <= PhHour;
        cnt_q        <= '0;
        hour_q       <= '0;
        minute_q     <= '0;
        second_q     <= '0;
        frac_q       <= '0;
        broken_q     <= 1'b0;
        blank_only_q <= 1'b1;
      end else begin
        phase_q      <= phase_d;
        cnt_q        <= cnt_d;
        hour_q       <= hour_d;
        minute_q     <= minute_d;
        second_q     <= second_d;
        frac_q       <= frac_d;
        broken_q     <= broken_d;
        blank_only_q <= blank_only_d;
      end
    end
  end

  `include "time_of_day_text_parser_unit_macros.svh"

  `TODP_ASSERT_SAME(a_cnt_in_range, 1'b1, cnt_q <= CntW'(FRACTION_DIGITS), "digit count overflow")
  `TODP_ASSERT_SAME(a_hms_two_digits, phase_q != PhFraction, cnt_q <= CntW'(2), "H/M/S count above two")
  `TODP_ASSERT_NEXT(a_clear_on_end, step_i && item_i.end_of_string, (cnt_q == '0) && blank_only_q && !broken_q, "state not cleared after end of string")

endmodule

/* hw/rtl/todp_judge.sv */
// Range checks, status encoding and the result register of the parser.
`timescale 1ns / 1ps
module todp_judge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  todp_pkg::scan_t      scan_i,
  output logic                 free_o,
  todp_stream_if.source        out_o
);
  import todp_pkg::*;

  status_e status;
  result_t res_d, res_q;
  logic    valid_q;

  always_comb begin
    priority if (scan_i.only_blank) begin
      status = StEmpty;
    end else if (scan_i.broken || (scan_i.phase != PhFraction) || scan_i.cnt_zero) begin
      status = StBadFormat;
    end else if (scan_i.hour > HourMax) begin
      status = StBadHour;
    end else if (scan_i.minute > MinSecMax) begin
      status = StBadMinute;
    end else if (scan_i.second > MinSecMax) begin
      status = StBadSecond;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = status;
    if (status == StOk) begin
      res_d.hour_value     = scan_i.hour[4:0];
      res_d.minute_value   = scan_i.minute[5:0];
      res_d.second_value   = scan_i.second[5:0];
      res_d.fraction_value = scan_i.fraction;
      res_d.resolution_us  = scan_i.frac_long;
    end
  end

  assign free_o      = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;
  assign out_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

endmodule

/* hw/rtl/time_of_day_text_parser_unit.sv */
// Top level of the streaming time-of-day text parser.
// A result is registered when its end-of-string item leaves the input register,
// which that item does not do while the result register still waits on the receiver.
// Throughput: one character per cycle while no end-of-string item is held back;
// the times-ten update of the field accumulators lies between the input and result registers.
// Reset clears the input stage, the result valid and all parser state at once.
`timescale 1ns / 1ps
module time_of_day_text_parser_unit #(
  parameter int unsigned FRACTION_DIGITS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  todp_stream_if.sink    in_i,
  todp_stream_if.source  out_o
);
  import todp_pkg::*;

  char_item_t s1_q;
  logic       s1_valid_q;
  logic       step;
  logic       load;
  logic       out_free;
  scan_t      scan;

  // A character without end mark never needs the result register.
  assign step     = s1_valid_q && (!s1_q.end_of_string || out_free);
  assign load     = step && s1_q.end_of_string;
  assign in_i.ready = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.payload;
    end
  end

  todp_scan #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_q),
    .scan_o (scan)
  );

  todp_judge u_judge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .scan_i (scan),
    .free_o (out_free),
    .out_o  (out_o)
  );

  `include "time_of_day_text_parser_unit_macros.svh"

  `TODP_ASSERT_NEXT(a_end_gives_result, load, out_o.valid, "end of string gave no result")
  `TODP_ASSERT_NEXT(a_blocked_end_holds, s1_valid_q && s1_q.end_of_string && out_o.valid && !out_o.ready, s1_valid_q && s1_q.end_of_string, "blocked end item was dropped")
  `TODP_ASSERT_SAME(a_refill_needs_step, in_i.valid && in_i.ready && s1_valid_q, step, "input stage overwritten")

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the streaming time-of-day text parser.
`timescale 1ns / 1ps
module tb_top;
  import todp_pkg::*;

  localparam int unsigned FracDigits = 6;
  localparam int unsigned ItemTarget = 450;
  localparam int unsigned MinStrings = 20;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter  = 20;
  localparam int unsigned TailCycles = 10;

  typedef struct {
    char_item_t item;
    bit         drain_first;
  } char_stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  todp_stream_if #(.payload_t(char_item_t)) char_if ();
  todp_stream_if #(.payload_t(result_t))    time_if ();

  time_of_day_text_parser_unit #(
    .FRACTION_DIGITS(FracDigits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (char_if),
    .out_o (time_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  char_stim_t char_q[$];
  result_t    time_q[$];

  logic [7:0] blank_chars[6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

  int unsigned item_count;
  int unsigned char_count;
  int unsigned idle_count;
  int unsigned string_count;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned status_hits[6];
  int unsigned idle_cycles;

  // Predicted parser state, updated on every accepted character transfer.
  phase_e      scan_phase;
  int unsigned scan_digits;
  logic [6:0]  scan_hour;
  logic [6:0]  scan_minute;
  logic [6:0]  scan_second;
  logic [31:0] scan_fraction;
  bit          scan_broken;
  bit          scan_blank_only;

  function automatic void clear_scan();
    scan_phase      = PhHour;
    scan_digits     = 0;
    scan_hour       = '0;
    scan_minute     = '0;
    scan_second     = '0;
    scan_fraction   = '0;
    scan_broken     = 1'b0;
    scan_blank_only = 1'b1;
  endfunction

  // Returns 1 when the character ends a string, with the parsed time in res.
  function automatic bit parse_char_item(input char_item_t it, output result_t res);
    logic [7:0] c;
    logic [3:0] d;
    c = it.char_code;
    d = 4'(c - CharZero);
    res.status         = StOk;
    res.hour_value     = '0;
    res.minute_value   = '0;
    res.second_value   = '0;
    res.fraction_value = '0;
    res.resolution_us  = 1'b0;
    if (it.char_valid) begin
      if (c == CharSpace || (c >= CharTab && c <= CharCr)) begin
        scan_broken = 1'b1;
      end else begin
        scan_blank_only = 1'b0;
        if (!scan_broken) begin
          if (c >= CharZero && c <= CharNine) begin
            if (scan_phase == PhFraction) begin
              if (scan_digits >= FracDigits) begin
                scan_broken = 1'b1;
              end else begin
                scan_fraction = scan_fraction * 10 + d;
                scan_digits++;
              end
            end else if (scan_digits >= 2) begin
              scan_broken = 1'b1;
            end else begin
              case (scan_phase)
                PhHour:   scan_hour   = 7'(scan_hour * 10 + d);
                PhMinute: scan_minute = 7'(scan_minute * 10 + d);
                default:  scan_second = 7'(scan_second * 10 + d);
              endcase
              scan_digits++;
            end
          end else if (c == CharColon) begin
            if (scan_phase == PhFraction || scan_digits == 0) begin
              scan_broken = 1'b1;
            end else begin
              scan_phase  = phase_e'(scan_phase + 2'd1);
              scan_digits = 0;
            end
          end else if (c == CharDot) begin
            if (scan_phase != PhSecond || scan_digits == 0) begin
              scan_broken = 1'b1;
            end else begin
              scan_phase  = PhFraction;
              scan_digits = 0;
            end
          end else begin
            scan_broken = 1'b1;
          end
        end
      end
    end
    if (!it.end_of_string) return 1'b0;
    if (scan_blank_only) res.status = StEmpty;
    else if (scan_broken || scan_phase != PhFraction || scan_digits == 0)
      res.status = StBadFormat;
    else if (scan_hour > HourMax) res.status = StBadHour;
    else if (scan_minute > MinSecMax) res.status = StBadMinute;
    else if (scan_second > MinSecMax) res.status = StBadSecond;
    else res.status = StOk;
    if (res.status == StOk) begin
      res.hour_value     = scan_hour[4:0];
      res.minute_value   = scan_minute[5:0];
      res.second_value   = scan_second[5:0];
      res.fraction_value = scan_fraction[FracW-1:0];
      res.resolution_us  = (scan_digits > MsDigitsMax);
    end
    clear_scan();
    return 1'b1;
  endfunction

  task automatic push_item(input logic [7:0] c, input bit v, input bit eos, input bit drain);
    char_stim_t s;
    s.item.char_code     = c;
    s.item.char_valid    = v;
    s.item.end_of_string = eos;
    s.drain_first        = drain;
    char_q.push_back(s);
    item_count++;
    if (v) char_count++;
    else if (!eos) idle_count++;
    if (eos) string_count++;
  endtask

  // Sends one string, with idle items sprinkled in; sep_end closes it with
  // an end mark that carries no character.
  task automatic send_chars(input logic [7:0] chars[$], input bit sep_end, input bit drain);
    bit first;
    first = drain;
    for (int i = 0; i < chars.size(); i++) begin
      if ($urandom_range(0, 7) == 0) begin
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, first);
        first = 1'b0;
      end
      push_item(chars[i], 1'b1, (i == chars.size() - 1) && !sep_end, first);
      first = 1'b0;
    end
    if (sep_end) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
  endtask

  task automatic add_text(input string s, input bit sep_end, input bit drain);
    logic [7:0] chars[$];
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    send_chars(chars, sep_end, drain);
  endtask

  // A well-formed time with random fields, now and then damaged.
  task automatic add_time_string(input bit drain);
    logic [7:0] chars[$];
    int unsigned limits[3];
    int unsigned val;
    int unsigned nd;
    limits = '{23, 59, 59};
    for (int f = 0; f < 3; f++) begin
      val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, limits[f]);
      nd  = (val < 10 && $urandom_range(0, 1) == 1) ? 1 : 2;
      if (nd == 2) chars.push_back(CharZero + 8'(val / 10));
      chars.push_back(CharZero + 8'(val % 10));
      if (f < 2 || $urandom_range(0, 1) == 1) chars.push_back(CharColon);
      else chars.push_back(CharDot);
    end
    nd = ($urandom_range(0, 7) == 0) ? FracDigits + 1 : $urandom_range(1, FracDigits);
    for (int i = 0; i < nd; i++) chars.push_back(CharZero + 8'($urandom_range(0, 9)));
    case ($urandom_range(0, 9))
      0: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
      1: chars.insert($urandom_range(0, chars.size()),
                      ($urandom_range(0, 1) == 1) ? CharColon : blank_chars[$urandom_range(0, 5)]);
      2: chars = chars[0:$urandom_range(0, chars.size() - 2)];
      default: ;
    endcase
    send_chars(chars, $urandom_range(0, 3) == 0, drain);
  endtask

  task automatic add_random_string(input bit drain);
    logic [7:0] chars[$];
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      add_time_string(drain);
    end else if (pick < 79) begin
      push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain);
    end else begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if (pick < 87) chars.push_back(8'($urandom_range(0, 255)));
        else if (pick < 92) chars.push_back(blank_chars[$urandom_range(0, 5)]);
        else begin
          case ($urandom_range(0, 11))
            10:      chars.push_back(CharColon);
            11:      chars.push_back(CharDot);
            default: chars.push_back(CharZero + 8'($urandom_range(0, 9)));
          endcase
        end
      end
      send_chars(chars, $urandom_range(0, 3) == 0, drain);
    end
  endtask

  // Character driver: bursts of transfers separated by random gaps.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_if.valid   <= 1'b0;
      char_if.payload <= '0;
      burst_left = 1;
      gap_left   = 0;
      clear_scan();
    end else begin
      bit      offer;
      result_t res;
      if (char_if.valid && char_if.ready) begin
        if (parse_char_item(char_if.payload, res)) time_q.push_back(res);
        void'(char_q.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (char_if.valid && !char_if.ready) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        offer = 1'b0;
      end else if (char_q.size() == 0) begin
        offer = 1'b0;
      end else if (char_q[0].drain_first && time_q.size() != 0) begin
        // Hold the next string back until every parsed time has come out.
        offer = 1'b0;
      end else begin
        offer = 1'b1;
      end
      char_if.valid <= offer;
      if (offer) char_if.payload <= char_q[0].item;
    end
  end

  // Result monitor and receiver stall pattern.
  int unsigned ready_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned cycle_count;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_if.ready <= 1'b0;
      ready_mode  = 0;
      mode_left   = 0;
      hold_left   = 0;
      hold_done   = 1'b0;
      cycle_count = 0;
    end else begin
      result_t want;
      result_t got;
      bit      rdy;
      if (time_if.valid && time_if.ready) begin
        got = time_if.payload;
        results_seen++;
        if (time_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d h %0d m %0d s %0d frac %0d us %0b",
                     got.status, got.hour_value, got.minute_value, got.second_value,
                     got.fraction_value, got.resolution_us);
        end else begin
          want = time_q.pop_front();
          status_hits[want.status]++;
          if (got.status !== want.status || got.hour_value !== want.hour_value ||
              got.minute_value !== want.minute_value ||
              got.second_value !== want.second_value ||
              got.fraction_value !== want.fraction_value ||
              got.resolution_us !== want.resolution_us) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d mismatch: expected status %0d h %0d m %0d s %0d ",
                        "frac %0d us %0b, got status %0d h %0d m %0d s %0d frac %0d us %0b"},
                       results_seen, want.status, want.hour_value, want.minute_value,
                       want.second_value, want.fraction_value, want.resolution_us,
                       got.status, got.hour_value, got.minute_value, got.second_value,
                       got.fraction_value, got.resolution_us);
          end
        end
      end
      cycle_count++;
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= HoldAfter) begin
        // One long stall so the parser backs up and refuses characters.
        hold_done = 1'b1;
        hold_left = HoldCycles;
        rdy = 1'b0;
      end else begin
        case (ready_mode)
          0:       rdy = 1'b1;
          1:       rdy = ($urandom_range(0, 1) == 1);
          2:       rdy = (cycle_count % 4 == 0);
          default: rdy = ($urandom_range(0, 6) != 0);
        endcase
      end
      time_if.ready <= rdy;
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (time_if.valid && time_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("timeout after %0d cycles without a transfer", IdleLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] chars[$];
    int unsigned strings_before;

    // Directed strings: field extremes, every status and the corner cases.
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    add_text("23:59:59.999999", 1'b0, 1'b0);
    add_text("0:0:0:0", 1'b0, 1'b0);
    chars = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    send_chars(chars, 1'b0, 1'b0);
    add_text("24:0:0.5", 1'b0, 1'b0);
    add_text("1:60:0.5", 1'b0, 1'b0);
    add_text("1:2:60.5", 1'b0, 1'b0);
    add_text("99:99:99.0", 1'b0, 1'b0);
    add_text("123:0:0.0", 1'b0, 1'b0);
    add_text("1:2:3.1234567", 1'b0, 1'b0);
    add_text("1::2:3.4", 1'b0, 1'b0);
    add_text("1.2:3.4", 1'b0, 1'b0);
    add_text("1:2:3", 1'b0, 1'b0);
    add_text("1:2:3.4:5", 1'b0, 1'b0);
    add_text(" 1:2:3.4", 1'b0, 1'b0);
    chars = '{8'hFF, 8'h00};
    send_chars(chars, 1'b0, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0, 1'b0);
    add_text("12:34:56.1234", 1'b1, 1'b1);
    add_text("7:8:9:789", 1'b0, 1'b0);

    strings_before = string_count;
    while (item_count < ItemTarget || string_count - strings_before < MinStrings)
      add_random_string((string_count % 10) == 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (char_q.size() != 0 || time_q.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    $display("Parsed %0d strings from %0d characters and %0d idle items, %0d results checked.",
             string_count, char_count, idle_count, results_seen);
    $display("Status mix: %0d ok, %0d bad format, %0d range errors, %0d empty; %0d mismatches.",
             status_hits[StOk], status_hits[StBadFormat],
             status_hits[StBadHour] + status_hits[StBadMinute] + status_hits[StBadSecond],
             status_hits[StEmpty], mismatch_count);
    if (mismatch_count == 0 && time_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
